>>> design/bresenham_line_rasterizer_macros.svh
// Assertion macros shared by the line rasterizer modules.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef BRESENHAM_LINE_RASTERIZER_MACROS_SVH
`define BRESENHAM_LINE_RASTERIZER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BRL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rasterizer check failed");

// Next-cycle implication, checked outside reset.
`define BRL_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rasterizer check failed");

`endif

>>> design/brl_pkg.sv
// Shared types and constants for the line rasterizer.
// Used by brl_front, brl_back and the top level; depends on nothing.
`default_nettype none

package brl_pkg;

  localparam int ScreenWidthDef  = 320;
  localparam int ScreenHeightDef = 200;

  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  localparam logic [1:0] STATUS_PIXEL     = 2'd0;
  localparam logic [1:0] STATUS_OFFSCREEN = 2'd1;
  localparam logic [1:0] STATUS_IDLE      = 2'd2;

  typedef struct packed {
    logic       cmd;
    logic [8:0] start_x;
    logic [7:0] start_y;
    logic [1:0] x_dir;
    logic [1:0] y_dir;
    logic       x_major;
    logic [8:0] major;
    logic [8:0] minor;
    logic [7:0] color;
  } cmd_t;

endpackage

`default_nettype wire

>>> design/brl_front.sv
// Front end: accepts command beats, works out deltas and directions,
// and holds decoded commands in a short queue. Depends on brl_pkg.
`default_nettype none

module brl_front (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  wire               command_i,
  input  wire  [8:0]        start_x_i,
  input  wire  [7:0]        start_y_i,
  input  wire  signed [9:0] run_i,
  input  wire  signed [8:0] rise_i,
  input  wire  [7:0]        line_color_i,
  output logic              cmd_valid_o,
  input  wire               cmd_pop_i,
  output brl_pkg::cmd_t     cmd_o
);

  logic signed [9:0] run_sat;
  logic [8:0] abs_run;
  logic [8:0] rise_mag;
  brl_pkg::cmd_t dec;

  brl_pkg::cmd_t mem_q [brl_pkg::QueueDepth];
  logic [brl_pkg::QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [brl_pkg::QueueCntW-1:0] count_q;
  logic push, pop;

  always_comb begin
    run_sat  = (run_i == -10'sd512) ? -10'sd511 : run_i;
    abs_run  = run_sat[9] ? 9'(-run_sat) : 9'(run_sat);
    rise_mag = rise_i[8] ? 9'(-rise_i) : 9'(rise_i);

    dec.cmd     = command_i;
    dec.start_x = start_x_i;
    dec.start_y = start_y_i;
    dec.color   = line_color_i;
    dec.x_dir   = (run_sat == 10'sd0) ? 2'b00 : (run_sat[9] ? 2'b11 : 2'b01);
    dec.y_dir   = (rise_i == 9'sd0) ? 2'b00 : (rise_i[8] ? 2'b11 : 2'b01);
    dec.x_major = abs_run >= rise_mag;
    dec.major   = dec.x_major ? abs_run : rise_mag;
    dec.minor   = dec.x_major ? rise_mag : abs_run;
  end

  assign in_ready_o  = count_q != brl_pkg::QueueCntW'(brl_pkg::QueueDepth);
  assign cmd_valid_o = count_q != '0;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= dec;
    end
  end

`include "bresenham_line_rasterizer_macros.svh"

  `BRL_ASSERT_IMP(a_queue_bound, 1'b1, count_q <= brl_pkg::QueueCntW'(brl_pkg::QueueDepth))
  `BRL_ASSERT_NXT(a_queue_fill, push && !pop, count_q != '0)

endmodule

`default_nettype wire

>>> design/brl_back.sv
// Back end: runs the Bresenham stepper on decoded commands, then forms the
// framebuffer address and status in an output register. Depends on brl_pkg.
`default_nettype none

module brl_back #(
  parameter int SCREEN_WIDTH  = brl_pkg::ScreenWidthDef,
  parameter int SCREEN_HEIGHT = brl_pkg::ScreenHeightDef
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           cmd_valid_i,
  output logic          cmd_pop_o,
  input  brl_pkg::cmd_t cmd_i,
  output logic          out_valid_o,
  input  wire           out_ready_i,
  output logic [15:0]   pixel_addr_o,
  output logic [7:0]    pixel_color_o,
  output logic [1:0]    status_o,
  output logic          last_o
);

  logic signed [10:0] cur_x_q, cur_x_d;
  logic signed [9:0]  cur_y_q, cur_y_d;
  logic [9:0] err_q, err_d;
  logic [8:0] steps_q, steps_d;
  logic [8:0] major_q, major_d;
  logic [8:0] minor_q, minor_d;
  logic [1:0] x_dir_q, x_dir_d;
  logic [1:0] y_dir_q, y_dir_d;
  logic       x_major_q, x_major_d;
  logic [7:0] color_q, color_d;
  logic       active_q, active_d;

  logic [9:0] err_sum;
  logic       minor_step;
  logic       step_x, step_y;

  logic       s1_valid_q;
  logic signed [10:0] s1_x_q;
  logic signed [9:0]  s1_y_q;
  logic [7:0] s1_color_q;
  logic       s1_last_q, s1_idle_q;
  logic       s1_last_d, s1_idle_d;

  logic       out_valid_q;
  logic [15:0] out_addr_q;
  logic [7:0] out_color_q;
  logic [1:0] out_status_q;
  logic       out_last_q;

  logic       out_load, s1_ready;
  logic       on_screen;
  logic [19:0] addr_full;

  assign out_load  = s1_valid_q && (!out_valid_q || out_ready_i);
  assign s1_ready  = !s1_valid_q || out_load;
  assign cmd_pop_o = cmd_valid_i && s1_ready;

  always_comb begin
    cur_x_d   = cur_x_q;
    cur_y_d   = cur_y_q;
    err_d     = err_q;
    steps_d   = steps_q;
    major_d   = major_q;
    minor_d   = minor_q;
    x_dir_d   = x_dir_q;
    y_dir_d   = y_dir_q;
    x_major_d = x_major_q;
    color_d   = color_q;
    active_d  = active_q;
    s1_idle_d = 1'b0;
    s1_last_d = 1'b0;

    err_sum    = err_q + 10'(minor_q);
    minor_step = err_sum >= 10'(major_q);
    step_x     = x_major_q || minor_step;
    step_y     = !x_major_q || minor_step;

    if (cmd_i.cmd == brl_pkg::CMD_START) begin
      cur_x_d   = 11'(cmd_i.start_x);
      cur_y_d   = 10'(cmd_i.start_y);
      x_dir_d   = cmd_i.x_dir;
      y_dir_d   = cmd_i.y_dir;
      x_major_d = cmd_i.x_major;
      major_d   = cmd_i.major;
      minor_d   = cmd_i.minor;
      color_d   = cmd_i.color;
      err_d     = 10'(cmd_i.major >> 1);
      steps_d   = cmd_i.major;
      active_d  = cmd_i.major != 9'd0;
      s1_last_d = cmd_i.major == 9'd0;
    end else if (!active_q) begin
      s1_idle_d = 1'b1;
    end else begin
      err_d = minor_step ? err_sum - 10'(major_q) : err_sum;
      if (step_x) begin
        cur_x_d = cur_x_q + {{9{x_dir_q[1]}}, x_dir_q};
      end
      if (step_y) begin
        cur_y_d = cur_y_q + {{8{y_dir_q[1]}}, y_dir_q};
      end
      steps_d   = steps_q - 9'd1;
      active_d  = steps_d != 9'd0;
      s1_last_d = !active_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      err_q       <= '0;
      steps_q     <= '0;
      major_q     <= '0;
      minor_q     <= '0;
      x_dir_q     <= '0;
      y_dir_q     <= '0;
      x_major_q   <= 1'b0;
      color_q     <= '0;
      active_q    <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_pop_o) begin
        cur_x_q   <= cur_x_d;
        cur_y_q   <= cur_y_d;
        err_q     <= err_d;
        steps_q   <= steps_d;
        major_q   <= major_d;
        minor_q   <= minor_d;
        x_dir_q   <= x_dir_d;
        y_dir_q   <= y_dir_d;
        x_major_q <= x_major_d;
        color_q   <= color_d;
        active_q  <= active_d;
      end
      if (s1_ready) begin
        s1_valid_q <= cmd_pop_o;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      s1_x_q     <= cur_x_d;
      s1_y_q     <= cur_y_d;
      s1_color_q <= color_d;
      s1_last_q  <= s1_last_d;
      s1_idle_q  <= s1_idle_d;
    end
  end

  assign on_screen = !s1_x_q[10] && ({1'b0, s1_x_q} < 12'(SCREEN_WIDTH)) &&
                     !s1_y_q[9] && ({1'b0, s1_y_q} < 11'(SCREEN_HEIGHT));
  assign addr_full = 20'(s1_y_q[8:0]) * 20'(SCREEN_WIDTH) + 20'(s1_x_q[9:0]);

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (s1_idle_q) begin
        out_addr_q   <= '0;
        out_color_q  <= '0;
        out_status_q <= brl_pkg::STATUS_IDLE;
        out_last_q   <= 1'b0;
      end else begin
        out_addr_q   <= on_screen ? addr_full[15:0] : 16'd0;
        out_color_q  <= s1_color_q;
        out_status_q <= on_screen ? brl_pkg::STATUS_PIXEL : brl_pkg::STATUS_OFFSCREEN;
        out_last_q   <= s1_last_q;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_addr_o  = out_addr_q;
  assign pixel_color_o = out_color_q;
  assign status_o      = out_status_q;
  assign last_o        = out_last_q;

`include "bresenham_line_rasterizer_macros.svh"

  `BRL_ASSERT_IMP(a_active_steps, 1'b1, active_q == (steps_q != 9'd0))
  `BRL_ASSERT_IMP(a_err_below_major, active_q, err_q < 10'(major_q))
  `BRL_ASSERT_IMP(a_idle_clean, out_valid_q && (out_status_q == brl_pkg::STATUS_IDLE),
                  (out_addr_q == 16'd0) && (out_color_q == 8'd0) && !out_last_q)
  `BRL_ASSERT_NXT(a_last_ends_line, cmd_pop_o && s1_last_d, !active_q)

endmodule

`default_nettype wire

>>> design/bresenham_line_rasterizer.sv
// Top level of the Bresenham line rasterizer.
// Instantiates brl_front and brl_back; depends on brl_pkg.
`default_nettype none

// Takes one command beat per cycle while s_axis_tready is high and gives
// exactly one pixel beat for each. A start command loads a line and returns
// its first pixel; each advance returns the next pixel, tlast marking the
// final one. Status tells whether the pixel is to be written, lies off
// screen, or no line was active. The stepper in the back end updates its
// error term once per cycle while commands are queued and the output is
// not stalled, so the sustained rate is then one pixel per clock. A beat is
// written into the two-entry command queue, then runs through the stepper,
// and the address multiply is then loaded into the output register.
module bresenham_line_rasterizer #(
  parameter int SCREEN_WIDTH  = brl_pkg::ScreenWidthDef,
  parameter int SCREEN_HEIGHT = brl_pkg::ScreenHeightDef
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // start_x[8:0], start_y[16:9], run[26:17], rise[35:27], line_color[43:36]
  input  wire  [47:0] s_axis_tdata,
  // command[0]
  input  wire  [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // pixel_addr[15:0], pixel_color[23:16]
  output logic [23:0] m_axis_tdata,
  // status[1:0]
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  logic          cmd_valid;
  logic          cmd_pop;
  brl_pkg::cmd_t cmd;
  logic [15:0]   pixel_addr;
  logic [7:0]    pixel_color;

  brl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .command_i    (s_axis_tuser[0]),
    .start_x_i    (s_axis_tdata[8:0]),
    .start_y_i    (s_axis_tdata[16:9]),
    .run_i        (s_axis_tdata[26:17]),
    .rise_i       (s_axis_tdata[35:27]),
    .line_color_i (s_axis_tdata[43:36]),
    .cmd_valid_o  (cmd_valid),
    .cmd_pop_i    (cmd_pop),
    .cmd_o        (cmd)
  );

  brl_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_pop_o     (cmd_pop),
    .cmd_i         (cmd),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .pixel_addr_o  (pixel_addr),
    .pixel_color_o (pixel_color),
    .status_o      (m_axis_tuser),
    .last_o        (m_axis_tlast)
  );

  assign m_axis_tdata = {pixel_color, pixel_addr};

endmodule

`default_nettype wire
